[rtl/core/lbd_pkg.sv]
// Package for the letterbox bar detector: sizes, register indexes and the
// structs passed between the row measurement and the bar hysteresis blocks.
// No dependencies.
`default_nettype none

package lbd_pkg;

  localparam int unsigned MAX_ROWS        = 2048;
  localparam int unsigned MAX_ROW_SAMPLES = 64;

  localparam int unsigned LUMA_W   = 8;
  localparam int unsigned ROW_W    = 11;
  localparam int unsigned HEIGHT_W = 12;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned TOL_W    = 8;
  localparam int unsigned GROW_W   = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [HEIGHT_W-1:0] MAX_ROWS_C        = HEIGHT_W'(MAX_ROWS);
  localparam logic [COUNT_W-1:0]  MAX_ROW_SAMPLES_C = COUNT_W'(MAX_ROW_SAMPLES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_HEIGHT   = 3'd0,
    REG_MAX_BAR_ROWS   = 3'd1,
    REG_LUMA_THRESHOLD = 3'd2,
    REG_MIN_BRIGHT     = 3'd3,
    REG_TOLERANCE_ROWS = 3'd4,
    REG_GROW_FRAMES    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] frame_height;
    logic [ROW_W-1:0]    max_bar_rows;
    logic [LUMA_W-1:0]   luma_threshold;
    logic [COUNT_W-1:0]  min_bright;
    logic [TOL_W-1:0]    tolerance_rows;
    logic [GROW_W-1:0]   grow_frames_needed;
  } cfg_t;

  typedef struct packed {
    logic             top_found;
    logic [ROW_W-1:0] top_bar;
    logic             bottom_found;
    logic [ROW_W-1:0] bottom_bar;
  } meas_t;

  typedef struct packed {
    logic [ROW_W-1:0] bar_rows;
    logic             changed;
    logic             undetermined;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/lbd_row_meas.sv]
// Row measurement: bright sample count per row and the top and bottom edge
// search of the current frame. Depends on lbd_pkg.
`default_nettype none

module lbd_row_meas (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [lbd_pkg::LUMA_W-1:0]  luma,
  input  wire logic [lbd_pkg::ROW_W-1:0]   row_index,
  input  wire logic                        row_end,
  input  wire logic                        frame_end,
  input  wire lbd_pkg::cfg_t               cfg,
  output lbd_pkg::meas_t                   meas_now
);

  logic [lbd_pkg::COUNT_W-1:0]  bright_count;
  logic [lbd_pkg::COUNT_W-1:0]  count_inc;
  logic [lbd_pkg::COUNT_W-1:0]  bright_count_next;
  lbd_pkg::meas_t               meas;
  lbd_pkg::meas_t               meas_next;
  logic [lbd_pkg::HEIGHT_W-1:0] height;
  logic [lbd_pkg::ROW_W-1:0]    rows_below;
  logic                         closing;
  logic                         picture;
  logic                         in_frame;

  always_comb begin
    if ((luma > cfg.luma_threshold) && (bright_count < lbd_pkg::MAX_ROW_SAMPLES_C)) begin
      count_inc = bright_count + lbd_pkg::COUNT_W'(1);
    end else begin
      count_inc = bright_count;
    end
    closing = row_end || frame_end;
    picture = count_inc >= cfg.min_bright;
    height = (cfg.frame_height < lbd_pkg::MAX_ROWS_C) ? cfg.frame_height
                                                      : lbd_pkg::MAX_ROWS_C;
    in_frame = {1'b0, row_index} < height;
    rows_below = lbd_pkg::ROW_W'(height - lbd_pkg::HEIGHT_W'(1) - {1'b0, row_index});

    meas_now = meas;
    if (closing && picture && in_frame) begin
      if ((row_index <= cfg.max_bar_rows) &&
          (!meas.top_found || (row_index < meas.top_bar))) begin
        meas_now.top_found = 1'b1;
        meas_now.top_bar   = row_index;
      end
      if ((rows_below <= cfg.max_bar_rows) &&
          (!meas.bottom_found || (rows_below < meas.bottom_bar))) begin
        meas_now.bottom_found = 1'b1;
        meas_now.bottom_bar   = rows_below;
      end
    end

    bright_count_next = closing ? '0 : count_inc;
    meas_next = frame_end ? '0 : meas_now;
    if (frame_end) begin
      bright_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_count <= '0;
      meas         <= '0;
    end else if (step) begin
      bright_count <= bright_count_next;
      meas         <= meas_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lbd_hyst.sv]
// Bar height hysteresis applied at frame end: shrink at once, grow after the
// bigger bars persist. Depends on lbd_pkg.
`default_nettype none

module lbd_hyst (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic           hold,
  input  wire lbd_pkg::meas_t meas_now,
  input  wire lbd_pkg::cfg_t  cfg,
  output lbd_pkg::result_t    result
);

  logic [lbd_pkg::ROW_W-1:0]    bar_size;
  logic [lbd_pkg::ROW_W-1:0]    bar_size_next;
  logic [lbd_pkg::GROW_W-1:0]   grow_count;
  logic [lbd_pkg::GROW_W-1:0]   grow_count_next;
  logic [lbd_pkg::GROW_W-1:0]   grow_inc;
  logic [lbd_pkg::ROW_W-1:0]    grow_pick;
  logic [lbd_pkg::ROW_W-1:0]    grow_pick_next;
  logic [lbd_pkg::ROW_W-1:0]    smaller;
  logic [lbd_pkg::ROW_W-1:0]    bigger;
  logic [lbd_pkg::HEIGHT_W-1:0] bigger_tol;
  logic [lbd_pkg::HEIGHT_W-1:0] size_tol;
  logic                         undet;

  always_comb begin
    undet = !meas_now.top_found || !meas_now.bottom_found;
    smaller = (meas_now.top_bar < meas_now.bottom_bar) ? meas_now.top_bar
                                                       : meas_now.bottom_bar;
    bigger = (meas_now.top_bar > meas_now.bottom_bar) ? meas_now.top_bar
                                                      : meas_now.bottom_bar;
    bigger_tol = {1'b0, bigger} + lbd_pkg::HEIGHT_W'(cfg.tolerance_rows);
    size_tol = {1'b0, bar_size} + lbd_pkg::HEIGHT_W'(cfg.tolerance_rows);
    grow_inc = grow_count + lbd_pkg::GROW_W'(1);

    bar_size_next = bar_size;
    grow_count_next = grow_count;
    grow_pick_next = grow_pick;
    if (!hold) begin
      if (undet) begin
        grow_count_next = '0;
      end else if (bigger_tol < {1'b0, bar_size}) begin
        bar_size_next = bigger;
        grow_count_next = '0;
      end else if ({1'b0, smaller} > size_tol) begin
        if ((grow_count == '0) || (smaller < grow_pick)) begin
          grow_pick_next = smaller;
        end
        grow_count_next = grow_inc;
        if (grow_inc >= cfg.grow_frames_needed) begin
          bar_size_next = grow_pick_next;
          grow_count_next = '0;
        end
      end else begin
        grow_count_next = '0;
      end
    end

    result.bar_rows = bar_size_next;
    result.changed = bar_size_next != bar_size;
    result.undetermined = undet;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_size   <= '0;
      grow_count <= '0;
      grow_pick  <= '0;
    end else if (step) begin
      bar_size   <= bar_size_next;
      grow_count <= grow_count_next;
      grow_pick  <= grow_pick_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/letterbox_bar_detector.sv]
// Top level of the letterbox bar detector: configuration registers, input
// register, result register. Depends on lbd_pkg, lbd_row_meas and lbd_hyst.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  luma, row_index, row_end, frame_end, hold
//   out      source     out_valid / out_stall bar_rows, changed, undetermined
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; a frame end item passes
// through the input register, and its result is then presented from the result register.
// Reset is synchronous and clears all control and measurement state.
// Input is stalled only while a frame end item waits behind an unaccepted
// result; other items keep flowing while a result waits.
`default_nettype none

module letterbox_bar_detector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lbd_pkg::LUMA_W-1:0]      luma,
  input  wire logic [lbd_pkg::ROW_W-1:0]       row_index,
  input  wire logic                            row_end,
  input  wire logic                            frame_end,
  input  wire logic                            hold,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lbd_pkg::ROW_W-1:0]            bar_rows,
  output logic                                 changed,
  output logic                                 undetermined,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lbd_pkg::cfg_t              cfg;
  lbd_pkg::meas_t             meas_now;
  lbd_pkg::result_t           result;
  logic                       s1_valid;
  logic [lbd_pkg::LUMA_W-1:0] s1_luma;
  logic [lbd_pkg::ROW_W-1:0]  s1_row_index;
  logic                       s1_row_end;
  logic                       s1_frame_end;
  logic                       s1_hold;
  logic                       s1_adv;
  logic                       in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid && s1_frame_end && out_valid && out_stall;
  assign s1_adv    = s1_valid && !in_stall;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_height       <= lbd_pkg::HEIGHT_W'(480);
      cfg.max_bar_rows       <= lbd_pkg::ROW_W'(144);
      cfg.luma_threshold     <= lbd_pkg::LUMA_W'(40);
      cfg.min_bright         <= lbd_pkg::COUNT_W'(8);
      cfg.tolerance_rows     <= lbd_pkg::TOL_W'(4);
      cfg.grow_frames_needed <= lbd_pkg::GROW_W'(90);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lbd_pkg::REG_FRAME_HEIGHT:   cfg.frame_height <= cfg_data;
        lbd_pkg::REG_MAX_BAR_ROWS:   cfg.max_bar_rows <= cfg_data[lbd_pkg::ROW_W-1:0];
        lbd_pkg::REG_LUMA_THRESHOLD: cfg.luma_threshold <= cfg_data[lbd_pkg::LUMA_W-1:0];
        lbd_pkg::REG_MIN_BRIGHT:     cfg.min_bright <= cfg_data[lbd_pkg::COUNT_W-1:0];
        lbd_pkg::REG_TOLERANCE_ROWS: cfg.tolerance_rows <= cfg_data[lbd_pkg::TOL_W-1:0];
        lbd_pkg::REG_GROW_FRAMES:
          cfg.grow_frames_needed <= cfg_data[lbd_pkg::GROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_luma      <= luma;
      s1_row_index <= row_index;
      s1_row_end   <= row_end;
      s1_frame_end <= frame_end;
      s1_hold      <= hold;
    end
  end

  lbd_row_meas u_meas (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .luma      (s1_luma),
    .row_index (s1_row_index),
    .row_end   (s1_row_end),
    .frame_end (s1_frame_end),
    .cfg       (cfg),
    .meas_now  (meas_now)
  );

  lbd_hyst u_hyst (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_adv && s1_frame_end),
    .hold     (s1_hold),
    .meas_now (meas_now),
    .cfg      (cfg),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_frame_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_frame_end) begin
      bar_rows     <= result.bar_rows;
      changed      <= result.changed;
      undetermined <= result.undetermined;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lbd_checker.sv]
// Port level checks for the letterbox bar detector, bound to the top level.
// Depends on letterbox_bar_detector and lbd_pkg.
`default_nettype none

module lbd_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [lbd_pkg::ROW_W-1:0]      bar_rows,
  input wire logic                           changed,
  input wire logic                           undetermined,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bar_rows) && $stable(changed)
      && $stable(undetermined))
    else $error("stalled result changed or dropped");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result register can drain");

  a_undet_no_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && undetermined |-> !changed)
    else $error("bar height changed on an undetermined frame");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind letterbox_bar_detector lbd_checker u_lbd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .bar_rows     (bar_rows),
  .changed      (changed),
  .undetermined (undetermined),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire

[verif/tb_letterbox_bar_detector.sv]
// Self-checking testbench for letterbox_bar_detector: streams rows of small and sparse
// frames, tracks the bar measurement and hysteresis in its own tracker, and checks every
// frame report. Depends on lbd_pkg and the letterbox_bar_detector RTL.
`timescale 1ns / 100ps

module tb_letterbox_bar_detector;

  typedef struct {
    logic [lbd_pkg::LUMA_W-1:0] luma;
    logic [lbd_pkg::ROW_W-1:0]  row_index;
    logic                       row_end;
    logic                       frame_end;
    logic                       hold;
  } sample_t;

  logic clk;
  logic rst = 1'b1;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [lbd_pkg::LUMA_W-1:0]     luma = '0;
  logic [lbd_pkg::ROW_W-1:0]      row_index = '0;
  logic                           row_end = 1'b0;
  logic                           frame_end = 1'b0;
  logic                           hold = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [lbd_pkg::ROW_W-1:0]      bar_rows;
  logic                           changed;
  logic                           undetermined;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lbd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  letterbox_bar_detector u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .luma         (luma),
    .row_index    (row_index),
    .row_end      (row_end),
    .frame_end    (frame_end),
    .hold         (hold),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bar_rows     (bar_rows),
    .changed      (changed),
    .undetermined (undetermined),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sample_t          samples_to_send[$];
  lbd_pkg::result_t bar_reports_due[$];
  sample_t          cur_sample;
  lbd_pkg::cfg_t    regs;
  int unsigned      staged = 0;
  int unsigned      mismatches = 0;
  int unsigned      burst_left = 0;
  int unsigned      gap_left = 0;
  int unsigned      stall_left = 0;
  int unsigned      stall_mode = 0;

  int unsigned row_bright = 0;
  bit          top_seen = 0;
  bit          bot_seen = 0;
  int unsigned top_dist = 0;
  int unsigned bot_dist = 0;
  int unsigned bar_now = 0;
  int unsigned grow_run = 0;
  int unsigned grow_target = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic track_sample(input sample_t s);
    int unsigned      h;
    int unsigned      rows_below;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      prev_bar;
    bit               undet;
    lbd_pkg::result_t r;
    h = (regs.frame_height < lbd_pkg::MAX_ROWS) ? regs.frame_height : lbd_pkg::MAX_ROWS;
    if (s.luma > regs.luma_threshold && row_bright < lbd_pkg::MAX_ROW_SAMPLES)
      row_bright++;
    if (s.row_end || s.frame_end) begin
      if (row_bright >= regs.min_bright && s.row_index < h) begin
        if (s.row_index <= regs.max_bar_rows && (!top_seen || s.row_index < top_dist)) begin
          top_seen = 1;
          top_dist = s.row_index;
        end
        rows_below = h - 1 - s.row_index;
        if (rows_below <= regs.max_bar_rows && (!bot_seen || rows_below < bot_dist)) begin
          bot_seen = 1;
          bot_dist = rows_below;
        end
      end
      row_bright = 0;
    end
    if (s.frame_end) begin
      prev_bar = bar_now;
      undet = !top_seen || !bot_seen;
      if (!s.hold) begin
        if (undet) begin
          grow_run = 0;
        end else begin
          lo = (top_dist < bot_dist) ? top_dist : bot_dist;
          hi = (top_dist > bot_dist) ? top_dist : bot_dist;
          if (hi + regs.tolerance_rows < bar_now) begin
            bar_now = hi;
            grow_run = 0;
          end else if (lo > bar_now + regs.tolerance_rows) begin
            if (grow_run == 0 || lo < grow_target) grow_target = lo;
            grow_run = (grow_run + 1) & 32'h3FF;
            if (grow_run >= regs.grow_frames_needed) begin
              bar_now = grow_target;
              grow_run = 0;
            end
          end else begin
            grow_run = 0;
          end
        end
      end
      r.bar_rows = lbd_pkg::ROW_W'(bar_now);
      r.changed = (bar_now != prev_bar);
      r.undetermined = undet;
      bar_reports_due.push_back(r);
      top_seen = 0;
      bot_seen = 0;
      top_dist = 0;
      bot_dist = 0;
    end
  endtask

  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_sample(cur_sample);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          nxt = samples_to_send.pop_front();
          cur_sample = nxt;
          luma <= nxt.luma;
          row_index <= nxt.row_index;
          row_end <= nxt.row_end;
          frame_end <= nxt.frame_end;
          hold <= nxt.hold;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[5];
    endcase
  end

  always @(posedge clk) begin : check_results
    lbd_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bar_reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: report with none pending: bar_rows=%0d changed=%0b undetermined=%0b",
                   $realtime, bar_rows, changed, undetermined);
      end else begin
        want = bar_reports_due.pop_front();
        if (want.bar_rows !== bar_rows || want.changed !== changed ||
            want.undetermined !== undetermined) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected bar_rows=%0d changed=%0b undetermined=%0b, got %0d %0b %0b",
                     $realtime, want.bar_rows, want.changed, want.undetermined,
                     bar_rows, changed, undetermined);
        end
      end
    end
  end

  task automatic write_reg(input lbd_pkg::reg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= lbd_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      lbd_pkg::REG_FRAME_HEIGHT:   regs.frame_height = lbd_pkg::HEIGHT_W'(val);
      lbd_pkg::REG_MAX_BAR_ROWS:   regs.max_bar_rows = lbd_pkg::ROW_W'(val);
      lbd_pkg::REG_LUMA_THRESHOLD: regs.luma_threshold = lbd_pkg::LUMA_W'(val);
      lbd_pkg::REG_MIN_BRIGHT:     regs.min_bright = lbd_pkg::COUNT_W'(val);
      lbd_pkg::REG_TOLERANCE_ROWS: regs.tolerance_rows = lbd_pkg::TOL_W'(val);
      lbd_pkg::REG_GROW_FRAMES:    regs.grow_frames_needed = lbd_pkg::GROW_W'(val);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(input int unsigned fh, input int unsigned mbr,
                               input int unsigned thr, input int unsigned mb,
                               input int unsigned tol, input int unsigned grow);
    write_reg(lbd_pkg::REG_FRAME_HEIGHT, fh);
    write_reg(lbd_pkg::REG_MAX_BAR_ROWS, mbr);
    write_reg(lbd_pkg::REG_LUMA_THRESHOLD, thr);
    write_reg(lbd_pkg::REG_MIN_BRIGHT, mb);
    write_reg(lbd_pkg::REG_TOLERANCE_ROWS, tol);
    write_reg(lbd_pkg::REG_GROW_FRAMES, grow);
  endtask

  task automatic settle();
    @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || bar_reports_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_sample(input int unsigned l, input int unsigned r, input bit re,
                            input bit fe, input bit hd);
    sample_t s;
    s.luma = lbd_pkg::LUMA_W'(l);
    s.row_index = lbd_pkg::ROW_W'(r);
    s.row_end = re;
    s.frame_end = fe;
    s.hold = hd;
    samples_to_send.push_back(s);
    staged++;
  endtask

  function automatic int unsigned pick_edge(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 2))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int unsigned pick_luma(input bit bright);
    int unsigned thr;
    thr = regs.luma_threshold;
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 255);
    if (bright) return (thr == 255) ? 255 : $urandom_range(thr + 1, 255);
    return $urandom_range(0, thr);
  endfunction

  // Picture rows lie between a top bar of t rows and a bottom bar of b rows.
  // Tall frames send only the rows around both bar edges and a few others.
  task automatic emit_frame(input int unsigned t, input int unsigned b,
                            input int unsigned nmax);
    int unsigned h;
    int unsigned rows[$];
    int          v;
    int unsigned i;
    int unsigned j;
    int unsigned n;
    int unsigned tmp;
    int unsigned pa;
    int unsigned pb;
    bit          desc;
    bit          bright;
    bit          re;
    bit          fe;
    bit          hd;
    h = (regs.frame_height < lbd_pkg::MAX_ROWS) ? regs.frame_height : lbd_pkg::MAX_ROWS;
    if (h == 0) begin
      repeat ($urandom_range(1, 3)) rows.push_back($urandom_range(0, lbd_pkg::MAX_ROWS - 1));
    end else if (h <= 24) begin
      desc = ($urandom_range(0, 7) == 0);
      for (i = 0; i < h; i++) begin
        if (desc) rows.push_front(i);
        else rows.push_back(i);
      end
      if ($urandom_range(0, 7) == 0) begin
        pa = $urandom_range(0, rows.size() - 1);
        pb = $urandom_range(0, rows.size() - 1);
        tmp = rows[pa];
        rows[pa] = rows[pb];
        rows[pb] = tmp;
      end
    end else begin
      for (j = 0; j < 4; j++) begin
        v = int'(t) + int'(j) - 2;
        if (v < 0) v = 0;
        if (v >= int'(h)) v = h - 1;
        rows.push_back(v);
      end
      for (j = 0; j < 4; j++) begin
        v = int'(h) - int'(b) - 2 + int'(j);
        if (v < 0) v = 0;
        if (v >= int'(h)) v = h - 1;
        rows.push_back(v);
      end
      rows.push_back($urandom_range(0, h - 1));
      rows.push_back($urandom_range(0, h - 1));
    end
    if ($urandom_range(0, 9) == 0) rows.push_back($urandom_range(0, lbd_pkg::MAX_ROWS - 1));
    for (i = 0; i < rows.size(); i++) begin
      bright = (rows[i] >= t) && (rows[i] + b < h);
      n = $urandom_range(1, nmax);
      for (j = 0; j < n; j++) begin
        fe = (i == rows.size() - 1) && (j == n - 1);
        re = (j == n - 1) ? 1'b1 : ($urandom_range(0, 39) == 0);
        if (fe) re = $urandom_range(0, 1);
        hd = fe ? ($urandom_range(0, 7) == 0) : $urandom_range(0, 1);
        add_sample(pick_luma(bright), rows[i], re, fe, hd);
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_start;
    int unsigned h;
    int unsigned t;
    int unsigned b;
    int unsigned span;
    int unsigned nmax;
    int unsigned fh;
    int unsigned mbr;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_settings(8, 7, 40, 1, 0, 1);
    // Threshold is exclusive; the frame end closes a row that had no row end.
    add_sample(255, 0, 1, 0, 0);
    add_sample(41, 7, 1, 0, 0);
    add_sample(0, 3, 0, 0, 1);
    add_sample(40, 3, 0, 1, 0);
    // Both bars grow to two rows; a row past the frame is ignored.
    add_sample(255, 2, 1, 0, 0);
    add_sample(255, 5, 1, 0, 0);
    add_sample(0, 2047, 1, 1, 0);
    // A held frame leaves the bar alone.
    add_sample(255, 3, 1, 0, 0);
    add_sample(255, 4, 1, 1, 1);
    // Rows out of order; the bar shrinks at once.
    add_sample(255, 6, 1, 0, 0);
    add_sample(255, 1, 1, 0, 0);
    add_sample(0, 4, 0, 1, 0);
    // A frame with no picture row.
    add_sample(0, 0, 1, 1, 0);
    settle();
    load_settings(0, 2047, 0, 0, 255, 0);
    add_sample(1, 0, 1, 0, 0);
    add_sample(0, 0, 1, 1, 0);
    settle();
    load_settings(4095, 2047, 255, 0, 255, 0);
    add_sample(0, 2047, 1, 0, 0);
    add_sample(255, 1023, 1, 0, 0);
    add_sample(128, 1024, 0, 1, 0);

    phase = 0;
    while (staged < 1800) begin
      phase++;
      settle();
      nmax = 3;
      case (phase % 8)
        3: begin
          case ($urandom_range(0, 5))
            0: fh = 0;
            1: fh = 1;
            2: fh = 2047;
            3: fh = 2048;
            4: fh = 4095;
            default: fh = $urandom_range(2, 4095);
          endcase
          load_settings(fh, pick_edge(0, 2047), pick_edge(0, 255), pick_edge(0, 127),
                        pick_edge(0, 255), pick_edge(0, 1023));
        end
        6: begin
          nmax = 70;
          load_settings($urandom_range(2, 4), 4, $urandom_range(0, 200),
                        $urandom_range(62, 66), $urandom_range(0, 2), $urandom_range(0, 3));
        end
        default: begin
          fh = $urandom_range(2, 16);
          mbr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, fh);
          load_settings(fh, mbr, $urandom_range(10, 220), $urandom_range(0, 3),
                        $urandom_range(0, 2), $urandom_range(0, 4));
        end
      endcase
      h = (regs.frame_height < lbd_pkg::MAX_ROWS) ? regs.frame_height : lbd_pkg::MAX_ROWS;
      span = (regs.max_bar_rows + 1 < h / 2) ? regs.max_bar_rows + 1 : h / 2;
      phase_start = staged;
      t = $urandom_range(0, span);
      b = $urandom_range(0, span);
      while (staged - phase_start < 160) begin
        if ($urandom_range(0, 99) < 35) begin
          t = $urandom_range(0, span);
          b = ($urandom_range(0, 1) == 0) ? t : $urandom_range(0, span);
        end
        emit_frame(t, b, nmax);
        if ($urandom_range(0, 19) == 0) settle();
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
